// ----- hw/rtl/packed_pixel_store_access_macros.svh -----
// Assertion macros shared by the packed pixel store RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef PACKED_PIXEL_STORE_ACCESS_MACROS_SVH
`define PACKED_PIXEL_STORE_ACCESS_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define PPSA_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PPSA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition never holds.
`define PPSA_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// ----- hw/rtl/ppsa_pkg.sv -----
// Types, codes and the fixed palette of the packed pixel store.
// No dependencies.
`default_nettype none

package ppsa_pkg;

   localparam logic [1:0] ACT_GET_PIXEL  = 2'd0;
   localparam logic [1:0] ACT_SET_PIXEL  = 2'd1;
   localparam logic [1:0] ACT_WRITE_BYTE = 2'd2;
   localparam logic [1:0] ACT_READ_BYTE  = 2'd3;

   localparam logic [1:0] MODE_1BPP = 2'd0;
   localparam logic [1:0] MODE_4BPP = 2'd1;
   localparam logic [1:0] MODE_8BPP = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_COLOR  = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;
   localparam logic [1:0] ST_INDEX     = 2'd3;

   localparam logic CSR_PIXEL_MODE = 1'b0;
   localparam logic CSR_ROW_WIDTH  = 1'b1;

   localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;
   localparam logic [23:0] COLOR_BLACK = 24'h000000;

   // y * stride (16 x 12 bits) plus column offset
   localparam int ADDR_CALC_W = 29;

   typedef struct packed {
      logic [1:0]  action;
      logic [10:0] pixel_x;
      logic [15:0] pixel_y;
      logic [23:0] set_color;
      logic [15:0] byte_address;
      logic [7:0]  byte_in;
   } req_type;

   typedef struct packed {
      logic [23:0] pixel_color;
      logic [7:0]  byte_out;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic                   out_of_range;
      logic [ADDR_CALC_W-1:0] byte_addr;
   } addr_info_type;

   function automatic logic [23:0] palette_color(input logic [3:0] idx);
      logic [23:0] c;
      case (idx)
         4'd0:    c = 24'h000000;
         4'd1:    c = 24'h000080;
         4'd2:    c = 24'h008000;
         4'd3:    c = 24'h008080;
         4'd4:    c = 24'h800000;
         4'd5:    c = 24'h800080;
         4'd6:    c = 24'h808000;
         4'd7:    c = 24'h808080;
         4'd8:    c = 24'hC0C0C0;
         4'd9:    c = 24'h0000FF;
         4'd10:   c = 24'h00FF00;
         4'd11:   c = 24'h00FFFF;
         4'd12:   c = 24'hFF0000;
         4'd13:   c = 24'hFF00FF;
         4'd14:   c = 24'hFFFF00;
         default: c = 24'hFFFFFF;
      endcase
      return c;
   endfunction

   // Returns {found, index}; lowest matching index wins.
   function automatic logic [4:0] palette_find(input logic [23:0] color);
      logic [4:0] r;
      r = 5'd0;
      for (int i = 15; i >= 0; i--) begin
         if (palette_color(4'(i)) == color) begin
            r = {1'b1, 4'(i)};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ppsa_addr.sv -----
// Byte address unit: row stride, y * stride product (registered) and range check.
// Depends on ppsa_pkg.
`default_nettype none

module ppsa_addr
   import ppsa_pkg::*;
#(
   parameter int STORE_BYTES   = 65536,
   parameter int MAX_ROW_WIDTH = 2048
) (
   input  wire logic          clock,
   input  wire logic          load,
   input  wire req_type       req,
   input  wire logic [1:0]    pixel_mode,
   input  wire logic [11:0]   row_width,
   output addr_info_type      info
);

   // The width register cannot exceed 4095, so a larger maximum never clamps.
   localparam int          ClampW  = (MAX_ROW_WIDTH > 4095) ? 4095 : MAX_ROW_WIDTH;
   localparam logic [11:0] CLAMP_W = 12'(ClampW);

   logic [11:0] width_masked;
   logic [11:0] width_clamped;
   logic [11:0] stride;
   logic [10:0] col_offset_in;
   logic [27:0] prod_in;
   logic        raw_in;

   logic [27:0] prod_ff;
   logic [10:0] col_offset_ff;
   logic        raw_ff;
   logic [15:0] raw_addr_ff;

   logic [ADDR_CALC_W-1:0] addr_sum;

   always_comb begin
      width_masked  = row_width & 12'hFF8;
      width_clamped = (width_masked > CLAMP_W) ? CLAMP_W : width_masked;
      case (pixel_mode)
         MODE_1BPP: begin
            stride        = {3'b000, width_clamped[11:3]};
            col_offset_in = {3'b000, req.pixel_x[10:3]};
         end
         MODE_8BPP: begin
            stride        = width_clamped;
            col_offset_in = req.pixel_x;
         end
         default: begin
            stride        = {1'b0, width_clamped[11:1]};
            col_offset_in = {1'b0, req.pixel_x[10:1]};
         end
      endcase
      prod_in = 28'(req.pixel_y) * 28'(stride);
      raw_in  = (req.action == ACT_WRITE_BYTE) || (req.action == ACT_READ_BYTE);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff       <= prod_in;
         col_offset_ff <= col_offset_in;
         raw_ff        <= raw_in;
         raw_addr_ff   <= req.byte_address;
      end
   end

   always_comb begin
      addr_sum          = raw_ff ? ADDR_CALC_W'(raw_addr_ff)
                                 : (ADDR_CALC_W'(prod_ff) + ADDR_CALC_W'(col_offset_ff));
      info.byte_addr    = addr_sum;
      info.out_of_range = (32'(addr_sum) >= 32'(STORE_BYTES));
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ppsa_mem.sv -----
// Byte store: one write port and one read port with registered read data.
// Depends on ppsa_pkg for nothing but house style; no contents are reset.
`default_nettype none

module ppsa_mem
   import ppsa_pkg::*;
#(
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [7:0]               rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [7:0]               wr_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/packed_pixel_store_access.sv -----
// Channel   Ports                               Accepted when
// request   start, busy, req_data               start && !busy at the clock edge
// result    rsp_valid, rsp_data                 edge ending the rsp_valid cycle
// config    csr_we, csr_index, csr_wdata        csr_we at the clock edge
//
// A request passes through accept (y * stride multiply), address add and store
// read, then modify/write-back with the result strobed. busy is high only in the
// address cycle, while the store read is in flight, so a new request is accepted
// in the result cycle, while the previous result is strobed.
// reset is synchronous; it clears control and configuration, not the store.
// The result is never stalled; it shows for exactly one cycle.
// Top level of the packed pixel store; uses ppsa_pkg, ppsa_addr, ppsa_mem and
// the assertion macro header.
`default_nettype none
`include "packed_pixel_store_access_macros.svh"

module packed_pixel_store_access
   import ppsa_pkg::*;
#(
   parameter int STORE_BYTES   = 65536,
   parameter int MAX_ROW_WIDTH = 2048
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire req_type       req_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  wire logic          csr_we,
   input  wire logic          csr_index,
   input  wire logic [11:0]   csr_wdata
);

   localparam int AW = $clog2(STORE_BYTES);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ADDR = 2'd1;
   localparam logic [1:0] S_MOD  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   logic [11:0] width_ff, width_in;
   req_type     req_ff;
   logic        oor_ff;
   logic [AW-1:0] addr_ff;

   logic          accept;
   addr_info_type ainfo;
   logic          mem_re, mem_we;
   logic [7:0]    mem_rdata, mem_wdata;

   logic [7:0]  cur;
   logic [2:0]  bit_sel;
   logic [7:0]  bit_mask;
   logic [4:0]  find;
   logic [3:0]  nibble;
   logic [23:0] pcol;
   logic [7:0]  bout;
   logic [1:0]  status;

   assign busy   = (state_ff == S_ADDR);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_ADDR;
         S_ADDR:  state_in = S_MOD;
         S_MOD:   state_in = accept ? S_ADDR : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      width_in = width_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PIXEL_MODE: mode_in  = csr_wdata[1:0];
            CSR_ROW_WIDTH:  width_in = csr_wdata;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= MODE_1BPP;
         width_ff <= 12'd8;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         width_ff <= width_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == S_ADDR) begin
         oor_ff  <= ainfo.out_of_range;
         addr_ff <= ainfo.byte_addr[AW-1:0];
      end
   end

   ppsa_addr #(
      .STORE_BYTES   (STORE_BYTES),
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
   ) u_addr (
      .clock      (clock),
      .load       (accept),
      .req        (req_data),
      .pixel_mode (mode_ff),
      .row_width  (width_ff),
      .info       (ainfo)
   );

   // A raw write needs no old byte; skip the read.
   assign mem_re = (state_ff == S_ADDR) && !ainfo.out_of_range
                   && (req_ff.action != ACT_WRITE_BYTE);

   ppsa_mem #(
      .DEPTH (STORE_BYTES)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_re),
      .rd_addr (ainfo.byte_addr[AW-1:0]),
      .rd_data (mem_rdata),
      .wr_en   (mem_we),
      .wr_addr (addr_ff),
      .wr_data (mem_wdata)
   );

   always_comb begin
      cur      = mem_rdata;
      bit_sel  = 3'd7 - req_ff.pixel_x[2:0];
      bit_mask = 8'h80 >> req_ff.pixel_x[2:0];
      find     = palette_find(req_ff.set_color);
      nibble   = req_ff.pixel_x[0] ? cur[3:0] : cur[7:4];
      pcol     = COLOR_BLACK;
      bout     = 8'd0;
      status   = ST_OK;
      mem_we   = 1'b0;
      mem_wdata = cur;
      if (state_ff == S_MOD) begin
         if (oor_ff) begin
            status = ST_RANGE;
         end else begin
            case (req_ff.action)
               ACT_WRITE_BYTE: begin
                  mem_we    = 1'b1;
                  mem_wdata = req_ff.byte_in;
               end
               ACT_READ_BYTE: begin
                  bout = cur;
               end
               ACT_GET_PIXEL: begin
                  case (mode_ff)
                     MODE_1BPP: pcol = cur[bit_sel] ? COLOR_WHITE : COLOR_BLACK;
                     MODE_8BPP: begin
                        if (cur[7:4] == 4'd0) pcol = palette_color(cur[3:0]);
                        else status = ST_INDEX;
                     end
                     default:   pcol = palette_color(nibble);
                  endcase
               end
               default: begin
                  // set pixel
                  if (mode_ff == MODE_1BPP) begin
                     mem_we    = 1'b1;
                     mem_wdata = (req_ff.set_color == COLOR_WHITE) ? (cur | bit_mask)
                                                                   : (cur & ~bit_mask);
                  end else if (!find[4]) begin
                     status = ST_NO_COLOR;
                  end else begin
                     mem_we = 1'b1;
                     if (mode_ff == MODE_8BPP) mem_wdata = {4'd0, find[3:0]};
                     else if (req_ff.pixel_x[0]) mem_wdata = {cur[7:4], find[3:0]};
                     else mem_wdata = {find[3:0], cur[3:0]};
                  end
               end
            endcase
         end
      end
   end

   assign rsp_valid            = (state_ff == S_MOD);
   assign rsp_data.pixel_color = pcol;
   assign rsp_data.byte_out    = bout;
   assign rsp_data.status      = status;

   `PPSA_ASSERT_NEXT(a_result_follows_addr, state_ff == S_ADDR, rsp_valid,
                     "result did not follow the address cycle")
   `PPSA_ASSERT_NEVER(a_no_read_write_overlap, mem_re && mem_we,
                      "store read and write in the same cycle")
   `PPSA_ASSERT_IMPLY(a_no_write_out_of_range, mem_we, rsp_valid && !oor_ff,
                      "store written outside a valid result cycle")
   `PPSA_ASSERT_IMPLY(a_range_zero_payload, rsp_valid && rsp_data.status == ST_RANGE,
                      rsp_data.pixel_color == COLOR_BLACK && rsp_data.byte_out == 8'd0,
                      "out-of-range result carries data")
   `PPSA_ASSERT_NEXT(a_accept_goes_busy, accept, busy,
                     "accepted request did not raise busy")

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for packed_pixel_store_access: directed pixel and raw byte
// requests, then random traffic under several modes and row widths. Depends on ppsa_pkg.

module tb_top;
   import ppsa_pkg::*;

   localparam int STORE_SIZE    = 65536;
   localparam int ROW_WIDTH_MAX = 2048;

   // fixed colors, entry 15 first
   localparam logic [15:0][23:0] PALETTE = {
      24'hFFFFFF, 24'hFFFF00, 24'hFF00FF, 24'hFF0000,
      24'h00FFFF, 24'h00FF00, 24'h0000FF, 24'hC0C0C0,
      24'h808080, 24'h808000, 24'h800080, 24'h800000,
      24'h008080, 24'h008000, 24'h000080, 24'h000000
   };

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we;
   logic        csr_index;
   logic [11:0] csr_wdata;

   logic [7:0]  image_bytes [STORE_SIZE];
   bit          image_loaded [STORE_SIZE];
   logic [1:0]  pixel_mode;
   logic [11:0] row_width;
   rsp_type     pending_rsp [$];
   rsp_type     expected_head;
   int          mismatch_count;
   int          sender_idle_pct;

   packed_pixel_store_access dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int bits_per_pixel();
      case (pixel_mode)
         MODE_1BPP: return 1;
         MODE_8BPP: return 8;
         default:   return 4;
      endcase
   endfunction

   function automatic longint row_stride();
      longint w;
      w = row_width & 12'hFF8;
      if (w > ROW_WIDTH_MAX) w = ROW_WIDTH_MAX;
      return w * bits_per_pixel() / 8;
   endfunction

   function automatic longint pixel_offset(logic [10:0] x, logic [15:0] y);
      return longint'(y) * row_stride() + longint'(x) * bits_per_pixel() / 8;
   endfunction

   function automatic int palette_index(logic [23:0] c);
      for (int i = 0; i < 16; i++)
         if (PALETTE[i] == c) return i;
      return -1;
   endfunction

   // Apply one request to the image copy and return the response it must give.
   function automatic rsp_type predict_access(req_type r);
      rsp_type    o;
      longint     a;
      logic [7:0] cur;
      int         idx;
      int         bpp;
      o = '0;
      case (r.action)
         ACT_WRITE_BYTE: begin
            image_bytes[r.byte_address] = r.byte_in;
            image_loaded[r.byte_address] = 1'b1;
         end
         ACT_READ_BYTE: o.byte_out = image_bytes[r.byte_address];
         default: begin
            bpp = bits_per_pixel();
            a = pixel_offset(r.pixel_x, r.pixel_y);
            if (a >= STORE_SIZE) begin
               o.status = ST_RANGE;
            end else begin
               cur = image_bytes[a];
               if (r.action == ACT_GET_PIXEL) begin
                  if (bpp == 1) begin
                     o.pixel_color = cur[7 - r.pixel_x[2:0]] ? COLOR_WHITE : COLOR_BLACK;
                  end else if (bpp == 8) begin
                     if (cur < 16) o.pixel_color = PALETTE[cur[3:0]];
                     else o.status = ST_INDEX;
                  end else begin
                     o.pixel_color = PALETTE[r.pixel_x[0] ? cur[3:0] : cur[7:4]];
                  end
               end else if (bpp == 1) begin
                  cur[7 - r.pixel_x[2:0]] = (r.set_color == COLOR_WHITE);
                  image_bytes[a] = cur;
               end else begin
                  idx = palette_index(r.set_color);
                  if (idx < 0) o.status = ST_NO_COLOR;
                  else if (bpp == 8) image_bytes[a] = 8'(idx);
                  else if (r.pixel_x[0]) image_bytes[a] = {cur[7:4], 4'(idx)};
                  else image_bytes[a] = {4'(idx), cur[3:0]};
               end
            end
         end
      endcase
      return o;
   endfunction

   function automatic req_type make_req(logic [1:0] action, logic [10:0] x, logic [15:0] y,
                                        logic [23:0] color, logic [15:0] addr,
                                        logic [7:0] data);
      req_type r;
      r.action       = action;
      r.pixel_x      = x;
      r.pixel_y      = y;
      r.set_color    = color;
      r.byte_address = addr;
      r.byte_in      = data;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      int      zone;
      int      ymax;
      longint  stride;
      r = make_req(2'($urandom), 11'($urandom), 16'($urandom), 24'($urandom),
                   16'($urandom), 8'($urandom));
      pick = $urandom_range(99);
      if (pick < 15) r.action = ACT_WRITE_BYTE;
      else if (pick < 30) r.action = ACT_READ_BYTE;
      else if (pick < 65) r.action = ACT_SET_PIXEL;
      else r.action = ACT_GET_PIXEL;
      if (r.action == ACT_WRITE_BYTE || r.action == ACT_READ_BYTE) begin
         if ($urandom_range(1) == 0) r.byte_address = 16'($urandom_range(255));
      end else begin
         zone = $urandom_range(99);
         stride = row_stride();
         if (zone < 60) begin
            // small window: revisit the same bytes so updates get read back
            r.pixel_x = 11'($urandom_range(63));
            r.pixel_y = 16'($urandom_range(7));
         end else if (zone < 85 && stride != 0) begin
            ymax = int'((65535 - r.pixel_x * bits_per_pixel() / 8) / stride);
            r.pixel_y = 16'($urandom_range(ymax));
         end
         pick = $urandom_range(99);
         if (pick < 60) r.set_color = PALETTE[$urandom_range(15)];
         else if (pick < 70) r.set_color = $urandom_range(1) ? COLOR_WHITE : COLOR_BLACK;
      end
      return r;
   endfunction

   task automatic note_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
   endtask

   task automatic send_request(req_type r);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(predict_access(r));
   endtask

   // Load the target byte first when it was never written, then send.
   task automatic access(req_type r);
      longint a;
      a = STORE_SIZE;
      if (r.action == ACT_READ_BYTE) a = r.byte_address;
      else if (r.action != ACT_WRITE_BYTE) a = pixel_offset(r.pixel_x, r.pixel_y);
      if (a < STORE_SIZE && !image_loaded[a])
         send_request(make_req(ACT_WRITE_BYTE, '0, '0, '0, 16'(a), 8'($urandom)));
      send_request(r);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(bit idx, logic [11:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_PIXEL_MODE) pixel_mode = value[1:0];
      else row_width = value;
   endtask

   task automatic configure(logic [1:0] mode, logic [11:0] width);
      drain_results();
      // upper bits of the mode write are don't-care
      write_csr(CSR_PIXEL_MODE, {10'($urandom), mode});
      write_csr(CSR_ROW_WIDTH, width);
   endtask

   task automatic test_raw_bytes();
      access(make_req(ACT_WRITE_BYTE, '0, '0, '0, 16'h0000, 8'hFF));
      access(make_req(ACT_WRITE_BYTE, 11'h7FF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 8'h00));
      access(make_req(ACT_READ_BYTE, '0, '0, '0, 16'h0000, '0));
      access(make_req(ACT_READ_BYTE, '0, '0, '0, 16'hFFFF, '0));
   endtask

   task automatic test_one_bpp();
      configure(MODE_1BPP, 12'd16);
      access(make_req(ACT_SET_PIXEL, 11'd0, 16'd0, COLOR_WHITE, '0, '0));
      access(make_req(ACT_SET_PIXEL, 11'd7, 16'd0, 24'hFFFFFE, '0, '0));
      access(make_req(ACT_GET_PIXEL, 11'd7, 16'd0, '0, '0, '0));
      access(make_req(ACT_GET_PIXEL, 11'd0, 16'd0, '0, '0, '0));
      // column past the row width runs into later rows
      access(make_req(ACT_GET_PIXEL, 11'd2047, 16'd0, '0, '0, '0));
      access(make_req(ACT_GET_PIXEL, 11'd0, 16'hFFFF, '0, '0, '0));
      access(make_req(ACT_SET_PIXEL, 11'd3, 16'hFFFF, COLOR_WHITE, '0, '0));
   endtask

   task automatic test_four_bpp();
      // unused mode code behaves as 4 bpp
      configure(2'd3, 12'd8);
      access(make_req(ACT_SET_PIXEL, 11'd0, 16'd0, 24'h000080, '0, '0));
      access(make_req(ACT_SET_PIXEL, 11'd1, 16'd0, 24'hFFFF00, '0, '0));
      access(make_req(ACT_GET_PIXEL, 11'd0, 16'd0, '0, '0, '0));
      access(make_req(ACT_GET_PIXEL, 11'd1, 16'd0, '0, '0, '0));
      access(make_req(ACT_SET_PIXEL, 11'd2, 16'd0, 24'h123456, '0, '0));
      configure(MODE_4BPP, 12'd8);
      access(make_req(ACT_GET_PIXEL, 11'd1, 16'd0, '0, '0, '0));
   endtask

   task automatic test_eight_bpp();
      configure(MODE_8BPP, 12'd8);
      access(make_req(ACT_WRITE_BYTE, '0, '0, '0, 16'd3, 8'h80));
      access(make_req(ACT_GET_PIXEL, 11'd3, 16'd0, '0, '0, '0));
      access(make_req(ACT_SET_PIXEL, 11'd3, 16'd0, COLOR_WHITE, '0, '0));
      access(make_req(ACT_GET_PIXEL, 11'd3, 16'd0, '0, '0, '0));
      access(make_req(ACT_WRITE_BYTE, '0, '0, '0, 16'd4, 8'h0F));
      access(make_req(ACT_GET_PIXEL, 11'd4, 16'd0, '0, '0, '0));
   endtask

   task automatic test_row_width();
      configure(MODE_8BPP, 12'd0);
      access(make_req(ACT_GET_PIXEL, 11'd5, 16'd1000, '0, '0, '0));
      // width saturates at the maximum row
      configure(MODE_8BPP, 12'hFFF);
      access(make_req(ACT_GET_PIXEL, 11'd0, 16'd31, '0, '0, '0));
      access(make_req(ACT_GET_PIXEL, 11'd0, 16'd32, '0, '0, '0));
      configure(MODE_8BPP, 12'd13);
      access(make_req(ACT_GET_PIXEL, 11'd1, 16'd1, '0, '0, '0));
   endtask

   task automatic test_random_traffic(int idle_pct, int phase);
      logic [11:0] width;
      sender_idle_pct = idle_pct;
      for (int seg = 0; seg < 4; seg++) begin
         case (seg)
            0:       width = 12'd8;
            1:       width = (phase == 1) ? 12'd4095 : 12'd2048;
            2:       width = 12'($urandom_range(8, 2047));
            default: width = 12'd0;
         endcase
         configure(2'(seg + phase), width);
         for (int n = 0; n < 110; n++) begin
            access(random_request());
            // hold off now and then until every response is back
            if ($urandom_range(99) == 0) drain_results();
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            note_failure($sformatf("unexpected response: color %h byte %h status %0d",
                                   rsp_data.pixel_color, rsp_data.byte_out,
                                   rsp_data.status));
         end else begin
            expected_head = pending_rsp.pop_front();
            if (rsp_data.pixel_color !== expected_head.pixel_color ||
                rsp_data.byte_out !== expected_head.byte_out ||
                rsp_data.status !== expected_head.status) begin
               note_failure($sformatf({"response mismatch: expected color %h byte %h ",
                                       "status %0d, got color %h byte %h status %0d"},
                                      expected_head.pixel_color, expected_head.byte_out,
                                      expected_head.status, rsp_data.pixel_color,
                                      rsp_data.byte_out, rsp_data.status));
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_data        = '0;
      csr_we          = 1'b0;
      csr_index       = CSR_PIXEL_MODE;
      csr_wdata       = '0;
      pixel_mode      = MODE_1BPP;
      row_width       = 12'd8;
      mismatch_count  = 0;
      sender_idle_pct = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_raw_bytes();
      test_one_bpp();
      test_four_bpp();
      test_eight_bpp();
      test_row_width();
      test_random_traffic(34, 0);
      test_random_traffic(73, 1);
      test_random_traffic(0, 2);

      drain_results();
      repeat (6) @(negedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ppsa_pkg.sv
hw/rtl/ppsa_addr.sv
hw/rtl/ppsa_mem.sv
hw/rtl/packed_pixel_store_access.sv
tb/sv/tb_top.sv
